### src/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// concurrent assertion wrappers, empty when synthesized
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("gjls assertion failed");

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("gjls assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

### src/gjls_pkg.sv
// ----------------------------------------------------------------------------
// gjls_pkg
// shared widths, codes and saturation helper for the linear solver
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gjls_pkg;

  localparam int VAL_W         = 32;
  localparam int ORDER_W       = 4;
  localparam int INDEX_W       = 3;
  localparam int MAX_ORDER_DEF = 8;
  localparam int FRAC_BITS_DEF = 16;

  localparam logic [ORDER_W-1:0] ORDER_RESET = 4'd8;

  localparam logic STATUS_OK         = 1'b0;
  localparam logic STATUS_ZERO_PIVOT = 1'b1;

  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

  // clamp a double width value into the value range
  function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [2*VAL_W-1:0] v);
    logic [VAL_W:0] top;
    begin
      top = v[2*VAL_W-1:VAL_W-1];
      if ((&top) || (~|top)) begin
        sat_val = v[VAL_W-1:0];
      end else if (v[2*VAL_W-1]) begin
        sat_val = VAL_MIN;
      end else begin
        sat_val = VAL_MAX;
      end
    end
  endfunction

endpackage

### src/gauss_jordan_linear_solver.sv
// ----------------------------------------------------------------------------
// gauss_jordan_linear_solver
// loads an n by n+1 augmented matrix, runs gauss-jordan elimination without
// pivoting in fixed point and gives the solution entries one per result
// ----------------------------------------------------------------------------
// channel  ports                        handshake
// config   cfg_wr_en, cfg_wr_data       written when cfg_wr_en is high
// input    in_element_value             taken when start && !busy
// result   out_status .. out_last_result one cycle, marked by out_valid
//
// loading takes an item whenever start is high and busy is low
// the last item starts the solve, which is paced by the bit-serial divider,
// once per ratio and once per solution entry, and by the three stage
// multiply-subtract per cell
// busy is high for the whole solve; results cannot be stalled
// rst_n is synchronous; a config write restarts the load
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gauss_jordan_linear_solver
  import gjls_pkg::*;
#(
  parameter int MAX_ORDER = MAX_ORDER_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_wr_en,
  input  logic [ORDER_W-1:0]      cfg_wr_data,
  input  logic                    start,
  input  logic signed [VAL_W-1:0] in_element_value,
  output logic                    busy,
  output logic                    out_valid,
  output logic                    out_status,
  output logic [INDEX_W-1:0]      out_entry_index,
  output logic signed [VAL_W-1:0] out_solution_value,
  output logic                    out_last_result
);

  localparam int STRIDE = MAX_ORDER + 1;
  localparam int DEPTH  = MAX_ORDER * STRIDE;
  localparam int AW     = $clog2(DEPTH);
  localparam int IW     = $clog2(MAX_ORDER + 2);

  typedef enum logic [13:0] {
    S_LOAD     = 14'b00000000000001,
    S_PIV_RD   = 14'b00000000000010,
    S_PIV_CHK  = 14'b00000000000100,
    S_ROW      = 14'b00000000001000,
    S_RAT_DIV  = 14'b00000000010000,
    S_RAT_WAIT = 14'b00000000100000,
    S_COL      = 14'b00000001000000,
    S_MUL      = 14'b00000010000000,
    S_MUL_WAIT = 14'b00000100000000,
    S_DIAG_RD  = 14'b00001000000000,
    S_DIAG_CHK = 14'b00010000000000,
    S_SOL_RD   = 14'b00100000000000,
    S_SOL_DIV  = 14'b01000000000000,
    S_SOL_WAIT = 14'b10000000000000
  } state_t;

  function automatic logic [AW-1:0] cell_addr(input logic [IW-1:0] r, input logic [IW-1:0] c);
    cell_addr = AW'(32'(r) * STRIDE + 32'(c));
  endfunction

  state_t state_r, state_nxt;
  logic [ORDER_W-1:0] order_r, order_nxt;
  logic [IW-1:0] load_row_r, load_row_nxt;
  logic [IW-1:0] load_col_r, load_col_nxt;
  logic [IW-1:0] i_r, i_nxt;
  logic [IW-1:0] j_r, j_nxt;
  logic [IW-1:0] k_r, k_nxt;
  logic signed [VAL_W-1:0] piv_r, piv_nxt;
  logic signed [VAL_W-1:0] ratio_r, ratio_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic                    out_status_r, out_status_nxt;
  logic [INDEX_W-1:0]      out_index_r, out_index_nxt;
  logic signed [VAL_W-1:0] out_value_r, out_value_nxt;
  logic                    out_last_r, out_last_nxt;

  logic [IW-1:0] n_eff;

  logic                    mem_we;
  logic [AW-1:0]           mem_waddr;
  logic signed [VAL_W-1:0] mem_wdata;
  logic [AW-1:0]           addr_a, addr_b;
  logic [VAL_W-1:0]        rd_a_raw, rd_b_raw;
  logic signed [VAL_W-1:0] rd_a, rd_b;

  logic                    div_start, div_done;
  logic signed [VAL_W-1:0] div_num, div_den, div_quo;
  logic                    ms_start, ms_done;
  logic signed [VAL_W-1:0] ms_result;

  assign rd_a = $signed(rd_a_raw);
  assign rd_b = $signed(rd_b_raw);

  always_comb begin
    if (order_r == '0) begin
      n_eff = IW'(1);
    end else if (32'(order_r) > 32'(MAX_ORDER)) begin
      n_eff = IW'(MAX_ORDER);
    end else begin
      n_eff = IW'(order_r);
    end
  end

  gjls_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr_a (addr_a),
    .rdata_a (rd_a_raw),
    .raddr_b (addr_b),
    .rdata_b (rd_b_raw)
  );

  gjls_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  gjls_mulsub #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mulsub (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (ms_start),
    .a      (ratio_r),
    .b      (rd_a),
    .c      (rd_b),
    .done   (ms_done),
    .result (ms_result)
  );

  always_comb begin
    state_nxt      = state_r;
    order_nxt      = order_r;
    load_row_nxt   = load_row_r;
    load_col_nxt   = load_col_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    k_nxt          = k_r;
    piv_nxt        = piv_r;
    ratio_nxt      = ratio_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_index_nxt  = out_index_r;
    out_value_nxt  = out_value_r;
    out_last_nxt   = out_last_r;
    mem_we         = 1'b0;
    mem_waddr      = cell_addr(j_r, k_r);
    mem_wdata      = '0;
    addr_a         = cell_addr(i_r, i_r);
    addr_b         = cell_addr(j_r, k_r);
    div_start      = 1'b0;
    div_num        = rd_a;
    div_den        = piv_r;
    ms_start       = 1'b0;

    case (state_r)
      S_LOAD: begin
        if (start) begin
          mem_we    = 1'b1;
          mem_waddr = cell_addr(load_row_r, load_col_r);
          mem_wdata = in_element_value;
          if (load_col_r == n_eff) begin
            load_col_nxt = '0;
            if (load_row_r == n_eff - IW'(1)) begin
              load_row_nxt = '0;
              i_nxt        = '0;
              state_nxt    = S_PIV_RD;
            end else begin
              load_row_nxt = load_row_r + IW'(1);
            end
          end else begin
            load_col_nxt = load_col_r + IW'(1);
          end
        end
      end
      S_PIV_RD: begin
        addr_a    = cell_addr(i_r, i_r);
        state_nxt = S_PIV_CHK;
      end
      S_PIV_CHK: begin
        if (rd_a == '0) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STATUS_ZERO_PIVOT;
          out_index_nxt  = INDEX_W'(i_r);
          out_value_nxt  = '0;
          out_last_nxt   = 1'b1;
          state_nxt      = S_LOAD;
        end else begin
          piv_nxt   = rd_a;
          j_nxt     = '0;
          state_nxt = S_ROW;
        end
      end
      S_ROW: begin
        addr_a = cell_addr(j_r, i_r);
        if (j_r == n_eff) begin
          if (i_r == n_eff - IW'(1)) begin
            i_nxt     = '0;
            state_nxt = S_DIAG_RD;
          end else begin
            i_nxt     = i_r + IW'(1);
            state_nxt = S_PIV_RD;
          end
        end else if (j_r == i_r) begin
          j_nxt = j_r + IW'(1);
        end else begin
          state_nxt = S_RAT_DIV;
        end
      end
      S_RAT_DIV: begin
        div_start = 1'b1;
        div_num   = rd_a;
        div_den   = piv_r;
        state_nxt = S_RAT_WAIT;
      end
      S_RAT_WAIT: begin
        if (div_done) begin
          ratio_nxt = div_quo;
          k_nxt     = '0;
          state_nxt = S_COL;
        end
      end
      S_COL: begin
        addr_a = cell_addr(i_r, k_r);
        addr_b = cell_addr(j_r, k_r);
        if (k_r > n_eff) begin
          j_nxt     = j_r + IW'(1);
          state_nxt = S_ROW;
        end else if (k_r == i_r) begin
          mem_we    = 1'b1;
          mem_waddr = cell_addr(j_r, k_r);
          mem_wdata = '0;
          k_nxt     = k_r + IW'(1);
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        ms_start  = 1'b1;
        state_nxt = S_MUL_WAIT;
      end
      S_MUL_WAIT: begin
        if (ms_done) begin
          mem_we    = 1'b1;
          mem_waddr = cell_addr(j_r, k_r);
          mem_wdata = ms_result;
          k_nxt     = k_r + IW'(1);
          state_nxt = S_COL;
        end
      end
      S_DIAG_RD: begin
        addr_a    = cell_addr(i_r, i_r);
        state_nxt = S_DIAG_CHK;
      end
      S_DIAG_CHK: begin
        if (rd_a == '0) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STATUS_ZERO_PIVOT;
          out_index_nxt  = INDEX_W'(i_r);
          out_value_nxt  = '0;
          out_last_nxt   = 1'b1;
          state_nxt      = S_LOAD;
        end else if (i_r == n_eff - IW'(1)) begin
          i_nxt     = '0;
          state_nxt = S_SOL_RD;
        end else begin
          i_nxt     = i_r + IW'(1);
          state_nxt = S_DIAG_RD;
        end
      end
      S_SOL_RD: begin
        addr_a    = cell_addr(i_r, n_eff);
        addr_b    = cell_addr(i_r, i_r);
        state_nxt = S_SOL_DIV;
      end
      S_SOL_DIV: begin
        div_start = 1'b1;
        div_num   = rd_a;
        div_den   = rd_b;
        state_nxt = S_SOL_WAIT;
      end
      S_SOL_WAIT: begin
        if (div_done) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STATUS_OK;
          out_index_nxt  = INDEX_W'(i_r);
          out_value_nxt  = div_quo;
          out_last_nxt   = (i_r == n_eff - IW'(1));
          if (i_r == n_eff - IW'(1)) begin
            state_nxt = S_LOAD;
          end else begin
            i_nxt     = i_r + IW'(1);
            state_nxt = S_SOL_RD;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase

    if (cfg_wr_en) begin
      order_nxt    = cfg_wr_data;
      load_row_nxt = '0;
      load_col_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      order_r     <= ORDER_RESET;
      load_row_r  <= '0;
      load_col_r  <= '0;
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      order_r     <= order_nxt;
      load_row_r  <= load_row_nxt;
      load_col_r  <= load_col_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    piv_r        <= piv_nxt;
    ratio_r      <= ratio_nxt;
    out_status_r <= out_status_nxt;
    out_index_r  <= out_index_nxt;
    out_value_r  <= out_value_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign busy               = (state_r != S_LOAD);
  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_entry_index    = out_index_r;
  assign out_solution_value = out_value_r;
  assign out_last_result    = out_last_r;

  `ASSERT_ALWAYS(a_last_then_idle, clk, rst_n, (out_valid_r && out_last_r) |-> (state_r == S_LOAD))
  `ASSERT_ALWAYS(a_error_is_last, clk, rst_n, (out_valid_r && out_status_r) |-> out_last_r)
  `ASSERT_ALWAYS(a_result_spacing, clk, rst_n, out_valid_r |=> !out_valid_r)

endmodule

### src/gjls_ram.sv
// ----------------------------------------------------------------------------
// gjls_ram
// generic one write, two read port ram with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gjls_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 72
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

### src/gjls_div.sv
// ----------------------------------------------------------------------------
// gjls_div
// bit-serial signed fixed-point divider, (num << frac) / den, saturated
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gjls_div
  import gjls_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [VAL_W-1:0] num,
  input  logic signed [VAL_W-1:0] den,
  output logic                    done,
  output logic signed [VAL_W-1:0] quo
);

  localparam int NW = VAL_W + FRAC_BITS;
  localparam int CW = $clog2(NW + 1);
  localparam logic [NW-1:0] NEG_LIMIT = NW'(1) << (VAL_W - 1);
  localparam logic [NW-1:0] POS_LIMIT = NEG_LIMIT - NW'(1);

  logic          run_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [NW-1:0] dvd_r;
  logic [NW-1:0] qm_r;
  logic [VAL_W-1:0] rem_r;
  logic [VAL_W-1:0] den_r;
  logic          neg_r;

  logic [VAL_W-1:0] num_mag;
  logic [VAL_W-1:0] den_mag;
  logic [VAL_W:0]   rem_sh;
  logic             ge;
  logic [VAL_W:0]   rem_diff;
  logic [VAL_W-1:0] rem_nxt;

  always_comb begin
    num_mag  = num[VAL_W-1] ? VAL_W'(-num) : VAL_W'(num);
    den_mag  = den[VAL_W-1] ? VAL_W'(-den) : VAL_W'(den);
    rem_sh   = {rem_r, dvd_r[NW-1]};
    ge       = (rem_sh >= {1'b0, den_r});
    rem_diff = rem_sh - {1'b0, den_r};
    rem_nxt  = ge ? rem_diff[VAL_W-1:0] : rem_sh[VAL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CW'(NW);
      end else if (run_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= {num_mag, {FRAC_BITS{1'b0}}};
      rem_r <= '0;
      qm_r  <= '0;
      den_r <= den_mag;
      neg_r <= num[VAL_W-1] ^ den[VAL_W-1];
    end else if (run_r) begin
      dvd_r <= dvd_r << 1;
      rem_r <= rem_nxt;
      qm_r  <= {qm_r[NW-2:0], ge};
    end
  end

  always_comb begin
    if (neg_r) begin
      quo = (qm_r > NEG_LIMIT) ? VAL_MIN : -$signed(qm_r[VAL_W-1:0]);
    end else begin
      quo = (qm_r > POS_LIMIT) ? VAL_MAX : $signed(qm_r[VAL_W-1:0]);
    end
  end

  assign done = done_r;

  `ASSERT_NEVER(a_div_no_restart, clk, rst_n, start && run_r)
  `ASSERT_ALWAYS(a_div_done_pulse, clk, rst_n, done_r |=> !done_r)

endmodule

### src/gjls_mulsub.sv
// ----------------------------------------------------------------------------
// gjls_mulsub
// three stage c - sat(a * b >> frac), truncated toward zero and saturated
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gjls_mulsub
  import gjls_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [VAL_W-1:0] a,
  input  logic signed [VAL_W-1:0] b,
  input  logic signed [VAL_W-1:0] c,
  output logic                    done,
  output logic signed [VAL_W-1:0] result
);

  logic v1_r, v2_r, v3_r;
  logic signed [2*VAL_W-1:0] p1_r;
  logic signed [VAL_W-1:0]   c1_r, c2_r, q2_r, res_r;

  logic signed [2*VAL_W-1:0] shifted;
  logic                      rnd;
  logic signed [2*VAL_W-1:0] q_wide;
  logic signed [2*VAL_W-1:0] d_wide;

  always_comb begin
    shifted = p1_r >>> FRAC_BITS;
    rnd     = p1_r[2*VAL_W-1] && (|p1_r[FRAC_BITS-1:0]);
    q_wide  = shifted + $signed((2*VAL_W)'(rnd));
    d_wide  = (2*VAL_W)'(c2_r) - (2*VAL_W)'(q2_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= start;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    p1_r  <= a * b;
    c1_r  <= c;
    q2_r  <= sat_val(q_wide);
    c2_r  <= c1_r;
    res_r <= sat_val(d_wide);
  end

  assign done   = v3_r;
  assign result = res_r;

endmodule

### verif/gjls_solution_checker.sv
// ----------------------------------------------------------------------------
// gjls_solution_checker
// watches the config, element and solution channels of the linear solver,
// keeps its own copy of the matrix, runs the elimination in fixed point when
// a load completes and compares every solution item against the prediction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gjls_solution_checker
  import gjls_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_wr_en,
  input  logic [ORDER_W-1:0]      cfg_wr_data,
  input  logic                    start,
  input  logic                    busy,
  input  logic signed [VAL_W-1:0] in_element_value,
  input  logic                    out_valid,
  input  logic                    out_status,
  input  logic [INDEX_W-1:0]      out_entry_index,
  input  logic signed [VAL_W-1:0] out_solution_value,
  input  logic                    out_last_result,
  output int                      mismatch_count,
  output int                      pending_count
);

  localparam int STRIDE = MAX_ORDER_DEF + 1;
  localparam int DEPTH  = MAX_ORDER_DEF * STRIDE;

  typedef struct packed {
    logic                    status;
    logic [INDEX_W-1:0]      index;
    logic signed [VAL_W-1:0] value;
    logic                    last;
  } solution_t;

  logic signed [VAL_W-1:0] mat [0:DEPTH-1];
  logic [ORDER_W-1:0]      order_reg;
  int                      load_cnt;
  solution_t               solution_q [$];
  int                      fails;

  initial begin
    mismatch_count = 0;
    pending_count  = 0;
    fails          = 0;
    order_reg      = ORDER_RESET;
    load_cnt       = 0;
  end

  function automatic logic signed [VAL_W-1:0] clamp32(input longint v);
    if (v > longint'(VAL_MAX)) return VAL_MAX;
    if (v < longint'(VAL_MIN)) return VAL_MIN;
    return v[VAL_W-1:0];
  endfunction

  function automatic logic signed [VAL_W-1:0] fx_prod(input logic signed [VAL_W-1:0] a,
                                                        input logic signed [VAL_W-1:0] b);
    longint p;
    p = longint'(a) * longint'(b);
    return clamp32(p / (longint'(1) << FRAC_BITS_DEF));
  endfunction

  function automatic logic signed [VAL_W-1:0] fx_quot(input logic signed [VAL_W-1:0] num,
                                                        input logic signed [VAL_W-1:0] den);
    longint q;
    q = (longint'(num) * (longint'(1) << FRAC_BITS_DEF)) / longint'(den);
    return clamp32(q);
  endfunction

  function automatic int active_order(input logic [ORDER_W-1:0] ord);
    if (ord == 0) return 1;
    if (ord > MAX_ORDER_DEF) return MAX_ORDER_DEF;
    return int'(ord);
  endfunction

  // eliminate in place, then queue the solution items or one zero pivot item
  function automatic void predict_solve(input int n);
    logic signed [VAL_W-1:0] piv;
    logic signed [VAL_W-1:0] ratio;
    logic signed [VAL_W-1:0] prod;
    solution_t               res;
    bit                      zero_hit;
    int                      bad_row;
    zero_hit = 1'b0;
    bad_row  = 0;
    for (int i = 0; i < n && !zero_hit; i++) begin
      piv = mat[i*STRIDE+i];
      if (piv == 0) begin
        zero_hit = 1'b1;
        bad_row  = i;
      end else begin
        for (int j = 0; j < n; j++) begin
          if (j != i) begin
            ratio = fx_quot(mat[j*STRIDE+i], piv);
            for (int k = 0; k <= n; k++) begin
              if (k == i) begin
                mat[j*STRIDE+k] = '0;
              end else begin
                prod = fx_prod(ratio, mat[i*STRIDE+k]);
                mat[j*STRIDE+k] = clamp32(longint'(mat[j*STRIDE+k]) - longint'(prod));
              end
            end
          end
        end
      end
    end
    for (int i = 0; i < n && !zero_hit; i++) begin
      if (mat[i*STRIDE+i] == 0) begin
        zero_hit = 1'b1;
        bad_row  = i;
      end
    end
    if (zero_hit) begin
      res.status = STATUS_ZERO_PIVOT;
      res.index  = bad_row[INDEX_W-1:0];
      res.value  = '0;
      res.last   = 1'b1;
      solution_q.push_back(res);
    end else begin
      for (int i = 0; i < n; i++) begin
        res.status = STATUS_OK;
        res.index  = i[INDEX_W-1:0];
        res.value  = fx_quot(mat[i*STRIDE+n], mat[i*STRIDE+i]);
        res.last   = (i == n - 1);
        solution_q.push_back(res);
      end
    end
  endfunction

  function automatic void take_element(input logic signed [VAL_W-1:0] v);
    int n;
    int cols;
    int total;
    n     = active_order(order_reg);
    cols  = n + 1;
    total = n * cols;
    if (load_cnt >= total) load_cnt = 0;
    mat[(load_cnt / cols) * STRIDE + (load_cnt % cols)] = v;
    load_cnt++;
    if (load_cnt >= total) begin
      load_cnt = 0;
      predict_solve(n);
    end
  endfunction

  always @(posedge clk) begin
    solution_t want;
    if (!rst_n) begin
      order_reg = ORDER_RESET;
      load_cnt  = 0;
      solution_q.delete();
    end else begin
      // results first, so a solve queued at this edge is not compared yet
      if (out_valid) begin
        if (solution_q.size() == 0) begin
          fails++;
          if (fails <= 10) begin
            $display("checker: unexpected result status %0d index %0d value %0d last %0d",
                     out_status, out_entry_index, out_solution_value, out_last_result);
          end
        end else begin
          want = solution_q.pop_front();
          if (out_status !== want.status || out_entry_index !== want.index ||
              out_solution_value !== want.value || out_last_result !== want.last) begin
            fails++;
            if (fails <= 10) begin
              $display("checker: mismatch want status %0d index %0d value %0d last %0d",
                       want.status, want.index, want.value, want.last);
              $display("checker:           got status %0d index %0d value %0d last %0d",
                       out_status, out_entry_index, out_solution_value, out_last_result);
            end
          end
        end
      end
      if (cfg_wr_en) begin
        order_reg = cfg_wr_data;
        load_cnt  = 0;
      end
      if (start && !busy) take_element(in_element_value);
    end
    mismatch_count <= fails;
    pending_count  <= solution_q.size();
  end

endmodule

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// stimulus for the gauss-jordan linear solver: directed matrices at the value
// extremes and zero pivots, then random matrices over many orders with random
// gaps, aborted loads and drains; the checker predicts and compares
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import gjls_pkg::*;

  localparam logic signed [VAL_W-1:0] ONE = 32'sh0001_0000;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_wr_en = 1'b0;
  logic [ORDER_W-1:0]      cfg_wr_data = '0;
  logic                    start = 1'b0;
  logic signed [VAL_W-1:0] in_element_value = '0;
  logic                    busy;
  logic                    out_valid;
  logic                    out_status;
  logic [INDEX_W-1:0]      out_entry_index;
  logic signed [VAL_W-1:0] out_solution_value;
  logic                    out_last_result;
  int                      mismatch_count;
  int                      pending;
  bit                      no_gaps = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  gauss_jordan_linear_solver dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .start              (start),
    .in_element_value   (in_element_value),
    .busy               (busy),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_entry_index    (out_entry_index),
    .out_solution_value (out_solution_value),
    .out_last_result    (out_last_result)
  );

  gjls_solution_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .start              (start),
    .busy               (busy),
    .in_element_value   (in_element_value),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_entry_index    (out_entry_index),
    .out_solution_value (out_solution_value),
    .out_last_result    (out_last_result),
    .mismatch_count     (mismatch_count),
    .pending_count      (pending)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [ORDER_W-1:0] pick_order();
    int r;
    r = $urandom_range(0, 99);
    if (r < 28) return 4'd1;
    if (r < 52) return 4'd2;
    if (r < 70) return 4'd3;
    if (r < 82) return ORDER_W'($urandom_range(4, 6));
    if (r < 88) return 4'd7;
    if (r < 92) return 4'd0;
    if (r < 96) return 4'd8;
    return ORDER_W'($urandom_range(9, 15));
  endfunction

  // style 0 diagonally dominant, 1 full range, 2 small integers, 3 mixed scale
  function automatic logic signed [VAL_W-1:0] make_element(input int style, input int r,
                                                             input int c, input int n);
    int t;
    case (style)
      0: begin
        if (c == n) begin
          t = int'($urandom_range(0, 2097152)) - 1048576;
        end else if (r == c) begin
          t = int'($urandom_range(n + 1, n + 4)) * 65536 + int'($urandom_range(0, 65535));
          if ($urandom_range(0, 1)) t = -t;
        end else begin
          t = int'($urandom_range(0, 131072)) - 65536;
        end
      end
      1: t = $urandom;
      2: t = (int'($urandom_range(0, 6)) - 3) * 65536;
      default: t = $signed($urandom) >>> $urandom_range(0, 28);
    endcase
    return t;
  endfunction

  task automatic send_element(input logic signed [VAL_W-1:0] v);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start            <= 1'b1;
    in_element_value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain_solutions();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
  endtask

  task automatic write_order(input logic [ORDER_W-1:0] v);
    drain_solutions();
    repeat (16) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    logic [ORDER_W-1:0] ord;
    int n;
    int total;
    int nmat;
    int style;
    int count;
    int random_items;
    int phase;

    random_items = 0;
    phase        = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // order one: value extremes, saturation both ways, zero pivot
    write_order(4'd1);
    send_element(ONE);        send_element(ONE);
    send_element(ONE);        send_element(VAL_MAX);
    send_element(32'sd1);     send_element(VAL_MAX);
    send_element(32'sd1);     send_element(VAL_MIN);
    send_element(-32'sd1);    send_element(VAL_MIN);
    send_element(VAL_MIN);    send_element(VAL_MIN);
    send_element('0);         send_element(32'sd5 <<< 16);

    // order zero runs as order one
    write_order(4'd0);
    send_element(-32'sd3 <<< 16);  send_element(32'sd6 <<< 16);
    send_element('0);              send_element('0);

    // singular order two: pivot of the second row vanishes after elimination
    write_order(4'd2);
    send_element(ONE); send_element(ONE); send_element(32'sd2 <<< 16);
    send_element(ONE); send_element(ONE); send_element(32'sd3 <<< 16);

    while (random_items < 150) begin
      ord = (phase == 0) ? 4'd8 : (phase == 1) ? 4'd15 : pick_order();
      n = (ord == 0) ? 1 : (ord > MAX_ORDER_DEF) ? MAX_ORDER_DEF : int'(ord);
      total = n * (n + 1);
      nmat = (n >= 6) ? 1 : $urandom_range(1, 3);
      no_gaps = ($urandom_range(0, 3) == 0);
      write_order(ord);
      for (int m = 0; m < nmat; m++) begin
        style = (phase == 0) ? 0 : $urandom_range(0, 3);
        count = total;
        // an aborted load is restarted by the next order write
        if (m == nmat - 1 && $urandom_range(0, 9) == 0) count = $urandom_range(1, total - 1);
        if ($urandom_range(0, 7) == 0) drain_solutions();
        for (int e = 0; e < count; e++) begin
          send_element(make_element(style, e / (n + 1), e % (n + 1), n));
          random_items++;
        end
      end
      phase++;
    end

    drain_solutions();
    repeat (64) @(posedge clk);
    if (mismatch_count == 0 && pending == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_top: errors");
    $finish;
  end

endmodule
